@@ sv/z_score_column_normalizer_top_assert.svh @@
// Assertion macros shared by the checker.
`ifndef Z_SCORE_COLUMN_NORMALIZER_TOP_ASSERT_SVH
`define Z_SCORE_COLUMN_NORMALIZER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge, suspended during reset.
`define ZSN_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ZSN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/zscn_pkg.sv @@
package zscn_pkg;
    localparam int MaxSamples = 64;
    localparam int AddrW = $clog2(MaxSamples);
    localparam int CountW = AddrW + 1;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               final_sample;
    } zscn_in_t;

    typedef struct packed {
        logic signed [15:0] normalized_value;
        logic signed [15:0] column_mean;
        logic        [15:0] column_std_dev;
        logic signed [15:0] column_min;
        logic signed [15:0] column_max;
        logic               zero_spread;
        logic               overflowed;
        logic               final_result;
    } zscn_out_t;

    // Column summary handed from the front end to the back end.
    typedef struct packed {
        logic [CountW-1:0]  count;
        logic signed [21:0] sum;
        logic signed [15:0] min_val;
        logic signed [15:0] max_val;
        logic               overflow;
        logic               enable;
    } zscn_col_t;
endpackage

@@ sv/zscn_ram.sv @@
module zscn_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ sv/zscn_front.sv @@
module zscn_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  normalize_enable,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  zscn_pkg::zscn_in_t    s_data,
    output logic                  wr_en,
    output logic [zscn_pkg::AddrW-1:0] wr_addr,
    output logic [15:0]           wr_data,
    output logic                  col_valid,
    input  logic                  col_ready,
    output zscn_pkg::zscn_col_t   col_data
);
    import zscn_pkg::*;

    logic [CountW-1:0]  count_reg, count_next;
    logic signed [21:0] sum_reg, sum_next;
    logic signed [15:0] min_reg, min_next, max_reg, max_next;
    logic               ovf_reg, ovf_next;
    logic               busy_reg, busy_next;
    logic               accept, room;

    // The front holds while the back end is still working on the previous column.
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign room    = count_reg < CountW'(MaxSamples);
    assign wr_en   = accept && room;
    assign wr_addr = count_reg[AddrW-1:0];
    assign wr_data = s_data.sample_value;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        col_valid  = 1'b0;
        col_data.count    = count_reg;
        col_data.sum      = sum_reg;
        col_data.min_val  = min_reg;
        col_data.max_val  = max_reg;
        col_data.overflow = ovf_reg;
        col_data.enable   = normalize_enable;
        if (accept) begin
            if (room) begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + 22'(s_data.sample_value);
                if (s_data.sample_value < min_reg) min_next = s_data.sample_value;
                if (s_data.sample_value > max_reg) max_next = s_data.sample_value;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_data.final_sample) begin
                busy_next = 1'b1;
            end
        end
        if (busy_reg) begin
            col_valid = 1'b1;
            if (col_ready) begin
                busy_next  = 1'b0;
                count_next = '0;
                sum_next   = '0;
                min_next   = 16'sh7FFF;
                max_next   = -16'sh8000;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= 16'sh7FFF;
            max_reg   <= -16'sh8000;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
        end
    end
endmodule

@@ sv/zscn_back.sv @@
module zscn_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  col_valid,
    output logic                  col_ready,
    input  zscn_pkg::zscn_col_t   col_data,
    output logic [zscn_pkg::AddrW-1:0] rd_addr,
    input  logic [15:0]           rd_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output zscn_pkg::zscn_out_t   m_data
);
    import zscn_pkg::*;

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StMean = 4'd1;
    localparam logic [3:0] StDevRd = 4'd2;
    localparam logic [3:0] StDevSq = 4'd3;
    localparam logic [3:0] StDevAcc = 4'd4;
    localparam logic [3:0] StVar = 4'd5;
    localparam logic [3:0] StSqrt = 4'd6;
    localparam logic [3:0] StEmRd = 4'd7;
    localparam logic [3:0] StEmDiv = 4'd8;
    localparam logic [3:0] StEmOut = 4'd9;
    localparam logic [3:0] StDone = 4'd10;

    logic [3:0]         state_reg, state_next;
    zscn_col_t          col_reg;
    logic [CountW-1:0]  idx_reg;
    logic [5:0]         step_reg;
    // Shared restoring divider: numerator magnitude (shifted out as the quotient shifts in), remainder, divisor.
    logic [37:0]        quo_reg;
    logic [37:0]        rem_reg;
    logic [21:0]        dvs_reg;
    logic               neg_reg;
    logic signed [15:0] mean_reg;
    logic signed [16:0] dev_reg;
    logic [33:0]        sq_reg;
    logic [37:0]        acc_reg;
    logic [37:0]        sq_rem_reg;
    logic [18:0]        root_reg;
    logic [15:0]        std_reg;
    logic signed [15:0] raw_reg;
    zscn_out_t          out_reg;
    logic               out_valid_reg;

    logic [38:0] trial;
    logic [38:0] rtrial;
    logic [37:0] rem_sh;
    logic [37:0] sqr_sh;
    logic        last_idx;

    assign rd_addr   = idx_reg[AddrW-1:0];
    assign col_ready = (state_reg == StDone);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign last_idx  = (idx_reg + 1'b1) == col_reg.count;

    assign rem_sh = {rem_reg[36:0], quo_reg[37]};
    assign trial  = {1'b0, rem_sh} - {17'd0, dvs_reg};
    // Digit-by-digit square root: two radicand bits per step.
    assign sqr_sh = {sq_rem_reg[35:0], acc_reg[37:36]};
    assign rtrial = {1'b0, sqr_sh} - {18'd0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= StIdle;
            out_valid_reg <= 1'b0;
        end else begin
            // While emitting, a taken result is replaced in the same cycle below.
            if (out_valid_reg && m_ready && state_reg != StEmOut) out_valid_reg <= 1'b0;
            unique case (state_reg)
                StIdle: begin
                    if (col_valid) begin
                        col_reg  <= col_data;
                        neg_reg  <= col_data.sum[21];
                        quo_reg  <= {16'd0, (col_data.sum[21] ? 22'(-col_data.sum)
                                                              : 22'(col_data.sum))};
                        rem_reg  <= '0;
                        dvs_reg  <= 22'(col_data.count);
                        step_reg <= 6'd37;
                        state_reg <= StMean;
                    end
                end
                StMean: begin
                    if (!trial[38]) begin
                        rem_reg <= trial[37:0];
                        quo_reg <= {quo_reg[36:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[36:0], 1'b0};
                    end
                    if (step_reg == 0) begin
                        state_reg <= StDevRd;
                        idx_reg   <= '0;
                        acc_reg   <= '0;
                    end
                    step_reg <= step_reg - 1'b1;
                end
                StDevRd: begin
                    if (quo_reg == '0) mean_reg <= '0;
                    else mean_reg <= neg_reg ? -quo_reg[15:0] : quo_reg[15:0];
                    state_reg <= StDevSq;
                end
                StDevSq: begin
                    dev_reg   <= 17'($signed(rd_data)) - 17'(mean_reg);
                    state_reg <= StDevAcc;
                end
                StDevAcc: begin
                    sq_reg  <= 34'($signed(dev_reg) * $signed(dev_reg));
                    if (last_idx) begin
                        state_reg <= StVar;
                    end else begin
                        // The registered store read must see the new address, so the pass goes back through StDevRd.
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= StDevRd;
                    end
                    if (idx_reg != 0) acc_reg <= acc_reg + 38'(sq_reg);
                end
                StVar: begin
                    if (step_reg == 6'h3F) begin
                        quo_reg  <= acc_reg + 38'(sq_reg);
                        rem_reg  <= '0;
                        step_reg <= 6'd37;
                    end else begin
                        if (!trial[38]) begin
                            rem_reg <= trial[37:0];
                            quo_reg <= {quo_reg[36:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[36:0], 1'b0};
                        end
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == 0) begin
                            state_reg <= StSqrt;
                            acc_reg   <= '0;
                            sq_rem_reg <= '0;
                            root_reg  <= '0;
                            step_reg  <= 6'd19;
                        end
                    end
                end
                StSqrt: begin
                    if (step_reg == 6'd19) begin
                        acc_reg  <= quo_reg;
                        step_reg <= 6'd18;
                    end else begin
                        acc_reg <= {acc_reg[35:0], 2'b00};
                        if (!rtrial[38]) begin
                            sq_rem_reg <= rtrial[37:0];
                            root_reg   <= {root_reg[17:0], 1'b1};
                        end else begin
                            sq_rem_reg <= sqr_sh;
                            root_reg   <= {root_reg[17:0], 1'b0};
                        end
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == 0) begin
                            state_reg <= StEmRd;
                            idx_reg   <= '0;
                        end
                    end
                end
                StEmRd: begin
                    std_reg   <= (root_reg[18:16] != '0) ? 16'hFFFF : root_reg[15:0];
                    state_reg <= StEmDiv;
                    step_reg  <= 6'h3F;
                end
                StEmDiv: begin
                    if (step_reg == 6'h3F) begin
                        raw_reg  <= $signed(rd_data);
                        dev_reg  <= 17'($signed(rd_data)) - 17'(mean_reg);
                        neg_reg  <= (17'($signed(rd_data)) - 17'(mean_reg)) < 0;
                        step_reg <= 6'h3E;
                    end else if (step_reg == 6'h3E) begin
                        quo_reg  <= {9'd0, (dev_reg < 0 ? 17'(-dev_reg) : 17'(dev_reg)), 12'd0};
                        rem_reg  <= '0;
                        dvs_reg  <= {6'd0, std_reg};
                        step_reg <= 6'd37;
                    end else begin
                        if (!trial[38]) begin
                            rem_reg <= trial[37:0];
                            quo_reg <= {quo_reg[36:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[36:0], 1'b0};
                        end
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == 0 || std_reg == 0) state_reg <= StEmOut;
                    end
                end
                StEmOut: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_reg.column_mean    <= mean_reg;
                        out_reg.column_std_dev <= std_reg;
                        out_reg.column_min     <= col_reg.min_val;
                        out_reg.column_max     <= col_reg.max_val;
                        out_reg.overflowed     <= col_reg.overflow;
                        out_reg.final_result   <= last_idx;
                        out_reg.zero_spread    <= col_reg.enable && std_reg == 0;
                        if (!col_reg.enable) out_reg.normalized_value <= raw_reg;
                        else if (std_reg == 0) out_reg.normalized_value <= '0;
                        else if (neg_reg)
                            out_reg.normalized_value <= (quo_reg > 38'd32768) ? -16'sh8000
                                                        : 16'(-quo_reg[15:0]);
                        else
                            out_reg.normalized_value <= (quo_reg > 38'd32767) ? 16'sh7FFF
                                                        : 16'(quo_reg[15:0]);
                        if (last_idx) begin
                            state_reg <= StDone;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= StEmRd;
                        end
                    end
                end
                StDone: state_reg <= StIdle;
                default: state_reg <= StIdle;
            endcase
        end
    end
endmodule

@@ sv/z_score_column_normalizer_top.sv @@
// Samples are taken one per cycle unless input stalls; the closing sample hands the
// column to the back end. Back end per column: a mean divide, a deviation pass over
// the stored samples, a variance divide and square root, then a divide per emitted
// result, sharing one radix-2 divider. Input stalls while a column is in the back end.
// Reset (synchronous, aresetn low) clears the front end's column statistics and sets normalize_enable to 1.
module z_score_column_normalizer_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  zscn_pkg::zscn_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output zscn_pkg::zscn_out_t   m_data
);
    import zscn_pkg::*;

    logic              enable_reg;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr, rd_addr;
    logic [15:0]       wr_data, rd_data;
    logic              col_valid, col_ready;
    zscn_col_t         col_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) enable_reg <= 1'b1;
        else if (cfg_wr_en) enable_reg <= cfg_wr_data;
    end

    zscn_ram #(.Width(16), .Depth(MaxSamples)) u_store (
        .aclk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
    );

    zscn_front u_front (
        .aclk, .aresetn, .normalize_enable(enable_reg), .s_valid, .s_ready, .s_data,
        .wr_en, .wr_addr, .wr_data, .col_valid, .col_ready, .col_data
    );

    zscn_back u_back (
        .aclk, .aresetn, .col_valid, .col_ready, .col_data, .rd_addr, .rd_data,
        .m_valid, .m_ready, .m_data
    );
endmodule

@@ sv/zscn_checker.sv @@
`include "z_score_column_normalizer_top_assert.svh"
module zscn_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input zscn_pkg::zscn_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input zscn_pkg::zscn_out_t m_data
);
    import zscn_pkg::*;

    `ZSN_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result dropped while stalled")
    `ZSN_ASSERT_IMP(a_min_max, aclk, aresetn, m_valid,
        m_data.column_min <= m_data.column_max, "min above max")
    `ZSN_ASSERT_IMP(a_zero, aclk, aresetn, m_valid && m_data.zero_spread,
        m_data.normalized_value == 0 && m_data.column_std_dev == 0, "zero spread value")
    `ZSN_ASSERT_NEXT(a_close, aclk, aresetn, s_valid && s_ready && s_data.final_sample,
        !s_ready, "input open after closing sample")
endmodule

bind z_score_column_normalizer_top zscn_checker u_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
);

@@ verif/z_score_column_normalizer_top_tb.sv @@
module z_score_column_normalizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zscn_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 400;
    localparam int IdleFreeStart = 120;
    localparam int IdleFreeEnd = 190;

    localparam int ModeRandom = 0;
    localparam int ModeConstant = 1;
    localparam int ModeNarrow = 2;
    localparam int ModeExtreme = 3;

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic      cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    zscn_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    zscn_out_t m_data;

    z_score_column_normalizer_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Predictor state for the column being gathered.
    logic signed [15:0] col_store [MaxSamples];
    int                 col_count;
    longint             col_sum;
    int                 col_min;
    int                 col_max;
    bit                 col_dropped;
    bit                 norm_on;

    zscn_in_t  pending_samples [$];
    zscn_out_t expected_results [$];
    int        error_count;
    int        cycle_count;
    int        sent_count = 0;
    bit        idle_free;
    bit        hold_sender;

    // Both sides run without idling over one stretch of the input sequence.
    assign idle_free = (sent_count >= IdleFreeStart) && (sent_count < IdleFreeEnd);

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    task automatic clear_column();
        col_count = 0;
        col_sum = 0;
        col_min = 32767;
        col_max = -32768;
        col_dropped = 0;
    endtask

    task automatic predict_sample(zscn_in_t item);
        longint    mean;
        longint    d;
        longint unsigned sq;
        longint    sd;
        longint    nv;
        zscn_out_t r;
        int        x;
        x = item.sample_value;
        if (col_count < MaxSamples) begin
            col_store[col_count] = item.sample_value;
            col_count++;
            col_sum += x;
            if (x < col_min) col_min = x;
            if (x > col_max) col_max = x;
        end else begin
            col_dropped = 1;
        end
        if (item.final_sample) begin
            mean = col_sum / col_count;
            sq = 0;
            for (int i = 0; i < col_count; i++) begin
                d = longint'(col_store[i]) - mean;
                sq += longint'(d * d);
            end
            sd = int_sqrt(sq / col_count);
            if (sd > 65535) sd = 65535;
            for (int i = 0; i < col_count; i++) begin
                r.zero_spread = 1'b0;
                if (!norm_on) begin
                    nv = col_store[i];
                end else if (sd == 0) begin
                    nv = 0;
                    r.zero_spread = 1'b1;
                end else begin
                    nv = ((longint'(col_store[i]) - mean) * 4096) / sd;
                    if (nv > 32767) nv = 32767;
                    if (nv < -32768) nv = -32768;
                end
                r.normalized_value = nv[15:0];
                r.column_mean = mean[15:0];
                r.column_std_dev = sd[15:0];
                r.column_min = col_min[15:0];
                r.column_max = col_max[15:0];
                r.overflowed = col_dropped;
                r.final_result = (i + 1 == col_count);
                expected_results.insert(expected_results.size(), r);
            end
            clear_column();
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Driver: presents queued samples; idling is decided only while no transaction is held.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_sample(s_data);
                sent_count++;
            end
            if (!(s_valid && !s_ready)) begin
                if (s_valid && s_ready) void'(pending_samples.pop_front());
                if (pending_samples.size() != 0 && !hold_sender
                        && (idle_free || $urandom_range(99) >= 38)) begin
                    s_valid <= 1'b1;
                    s_data <= pending_samples[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        zscn_out_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= idle_free || $urandom_range(99) >= 38;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result count", 1, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_data.normalized_value !== w.normalized_value)
                        report_mismatch("normalized_value", m_data.normalized_value,
                                        w.normalized_value);
                    if (m_data.column_mean !== w.column_mean)
                        report_mismatch("column_mean", m_data.column_mean, w.column_mean);
                    if (m_data.column_std_dev !== w.column_std_dev)
                        report_mismatch("column_std_dev", m_data.column_std_dev,
                                        w.column_std_dev);
                    if (m_data.column_min !== w.column_min)
                        report_mismatch("column_min", m_data.column_min, w.column_min);
                    if (m_data.column_max !== w.column_max)
                        report_mismatch("column_max", m_data.column_max, w.column_max);
                    if (m_data.zero_spread !== w.zero_spread)
                        report_mismatch("zero_spread", m_data.zero_spread, w.zero_spread);
                    if (m_data.overflowed !== w.overflowed)
                        report_mismatch("overflowed", m_data.overflowed, w.overflowed);
                    if (m_data.final_result !== w.final_result)
                        report_mismatch("final_result", m_data.final_result, w.final_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_column(int len, int mode);
        zscn_in_t it;
        int base;
        base = $urandom_range(65535);
        for (int i = 0; i < len; i++) begin
            case (mode)
                ModeRandom: it.sample_value = 16'($urandom_range(65535));
                ModeConstant: it.sample_value = 16'(base);
                ModeNarrow: it.sample_value = 16'(base + int'($urandom_range(15)) - 8);
                default: it.sample_value = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
            endcase
            it.final_sample = (i == len - 1);
            pending_samples.insert(pending_samples.size(), it);
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_enable(bit v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        norm_on = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int given;
        zscn_in_t it;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_sender = 0;
        norm_on = 1;
        clear_column();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single sample, extremes, constant column, overfull column.
        it.sample_value = 16'sh7fff;
        it.final_sample = 1'b1;
        pending_samples.insert(pending_samples.size(), it);
        queue_column(2, ModeExtreme);
        queue_column(4, ModeConstant);
        queue_column(6, ModeExtreme);
        queue_column(MaxSamples + 3, ModeRandom);
        wait_idle();
        write_enable(1'b0);
        queue_column(5, ModeRandom);
        queue_column(3, ModeConstant);
        wait_idle();
        write_enable(1'b1);

        given = 0;
        while (given < 110) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(MaxSamples + 4, 40)
                                            : $urandom_range(12, 1);
            queue_column(len, $urandom_range(3));
            given += len;
            if ($urandom_range(4) == 0) begin
                // Let the block drain completely before feeding more.
                hold_sender = 1;
                while (s_valid || expected_results.size() != 0) @(posedge aclk);
                hold_sender = 0;
            end
            if ($urandom_range(5) == 0) begin
                wait_idle();
                write_enable($urandom_range(1));
            end
        end
        wait_idle();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
